// File: design/npc_pkg.sv
// Package for the nearest palette colour unit: sizes, command item, state codes
// and the squared-difference helper. Depends on nothing.
package npc_pkg;

    localparam int PALETTE_DEPTH = 32;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W         = 9;
    localparam int COUNT_W       = 6;
    localparam int CHAN_W        = 8;
    localparam int ENTRY_W       = 5;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [PADDR_W-3:0] REG_PALETTE_COUNT = '0;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_WRITE = 1'b1
    } npc_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } npc_state_t;

    typedef struct packed {
        logic              is_write;
        logic              wr_ok;
        logic              transparent;
        logic [IDX_W-1:0]  addr;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c0;
    } npc_cmd_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// File: design/npc_if.sv
// Channel interfaces of the nearest palette colour unit: input items and results.
// Depends on npc_pkg.
interface npc_in_if import npc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ENTRY_W-1:0] entry_index;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, kind, entry_index, chan0, chan1, chan2, alpha,
                    input ready);
    modport sink   (input valid, kind, entry_index, chan0, chan1, chan2, alpha,
                    output ready);
endinterface

interface npc_out_if import npc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic [CHAN_W-1:0] out_alpha;
    logic              matched;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_alpha, matched,
                    input ready);
    modport sink   (input valid, out_chan0, out_chan1, out_chan2, out_alpha, matched,
                    output ready);
endinterface

// File: design/npc_front.sv
// Front end: takes input items and classifies them into palette writes and pixels.
// Depends on npc_pkg and npc_in_if.
module npc_front import npc_pkg::*; (
    npc_in_if.sink    pix_in,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output npc_cmd_t  cmd
);

    assign cmd_valid    = pix_in.valid;
    assign pix_in.ready = cmd_ready;

    always_comb
    begin
        cmd.is_write    = (pix_in.kind == KIND_WRITE);
        // writes past the end of the palette are dropped
        cmd.wr_ok       = (CMP_W'(pix_in.entry_index) < CMP_W'(PALETTE_DEPTH));
        cmd.transparent = (pix_in.alpha == '0);
        cmd.addr        = IDX_W'(pix_in.entry_index);
        cmd.alpha       = pix_in.alpha;
        cmd.c2          = pix_in.chan2;
        cmd.c1          = pix_in.chan1;
        cmd.c0          = pix_in.chan0;
    end

endmodule

// File: design/npc_fifo.sv
// Short command queue between the front end and the search engine.
// Depends on npc_pkg.
module npc_fifo import npc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  npc_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output npc_cmd_t pop_data
);

    npc_cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  fill_reg, fill_next;
    logic                   push, pop;

    assign push_ready = (fill_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/npc_back.sv
// Back end: palette memory, sequential nearest-entry search and result register.
// Depends on npc_pkg and npc_out_if.
module npc_back import npc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] count,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  npc_cmd_t           cmd,
    npc_out_if.source          res_out
);

    logic [4*CHAN_W-1:0] palette_mem [PALETTE_DEPTH];

    npc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]    issue_inc;
    logic [CNT_W-1:0]    count_eff;
    logic                rd_en, mem_we, start_pixel, out_load, upd;

    logic                s1_valid_reg, s2_valid_reg;
    logic [4*CHAN_W-1:0] rd_data_reg;
    logic [4*CHAN_W-1:0] ent_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   dist_now;
    logic [CHAN_W-1:0]   pix_c0_reg, pix_c1_reg, pix_c2_reg;

    logic                found_reg, found_next;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [4*CHAN_W-1:0] best_entry_reg;

    logic                out_valid_reg;
    logic [4*CHAN_W-1:0] out_data_reg;
    logic                out_matched_reg;

    // counts above the depth behave as the full palette
    assign count_eff = (CMP_W'(count) > CMP_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                                 : CNT_W'(count);
    assign issue_inc = issue_cnt_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        cmd_ready      = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        start_pixel    = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.is_write)
                    begin
                        mem_we = cmd.wr_ok;
                    end
                    else
                    begin
                        start_pixel    = 1'b1;
                        issue_cnt_next = '0;
                        if (cmd.transparent || (count_eff == '0))
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en          = 1'b1;
                issue_cnt_next = issue_inc;
                if (issue_inc == count_eff)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // distance of the entry read last cycle
    assign dist_now = DIST_W'(sq_diff(rd_data_reg[CHAN_W-1:0], pix_c0_reg))
                    + DIST_W'(sq_diff(rd_data_reg[2*CHAN_W-1:CHAN_W], pix_c1_reg))
                    + DIST_W'(sq_diff(rd_data_reg[3*CHAN_W-1:2*CHAN_W], pix_c2_reg));

    // strict compare keeps the lowest index on a tie
    assign upd = s2_valid_reg && (!found_reg || (dist_reg < best_dist_reg));

    always_comb
    begin
        found_next = found_reg;
        if (start_pixel)
        begin
            found_next = 1'b0;
        end
        else if (upd)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_valid_reg  <= rd_en;
            s2_valid_reg  <= s1_valid_reg;
            found_reg     <= found_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[cmd.addr] <= {cmd.alpha, cmd.c2, cmd.c1, cmd.c0};
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_pixel)
        begin
            pix_c0_reg <= cmd.c0;
            pix_c1_reg <= cmd.c1;
            pix_c2_reg <= cmd.c2;
        end
        dist_reg <= dist_now;
        ent_reg  <= rd_data_reg;
        if (upd)
        begin
            best_dist_reg  <= dist_reg;
            best_entry_reg <= ent_reg;
        end
        if (out_load)
        begin
            out_data_reg    <= found_reg ? best_entry_reg : '0;
            out_matched_reg <= found_reg;
        end
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.out_chan0 = out_data_reg[CHAN_W-1:0];
    assign res_out.out_chan1 = out_data_reg[2*CHAN_W-1:CHAN_W];
    assign res_out.out_chan2 = out_data_reg[3*CHAN_W-1:2*CHAN_W];
    assign res_out.out_alpha = out_data_reg[4*CHAN_W-1:3*CHAN_W];
    assign res_out.matched   = out_matched_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg < count_eff))
        else $error("scan index beyond palette count");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("compare stage valid without a preceding read");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("result emitted with entries still in flight");

    a_pixel_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_pixel |=> ((state_reg == ST_SCAN) || (state_reg == ST_EMIT)))
        else $error("pixel item did not start a search or a result");

endmodule

// File: design/nearest_palette_color_unit.sv
// Top level of the nearest palette colour unit: APB register, front end, queue, back end.
// Depends on npc_pkg, npc_if, npc_front, npc_fifo and npc_back.
//
// Usage:
//   pix_in carries items with valid/ready. kind 1 writes the four channels into palette
//   entry entry_index and gives no result; kind 0 is a pixel and gives one result on
//   res_out: the closest entry (squared RGB distance, lowest index on a tie) among the
//   first palette_count entries, with matched set, or all zeros when the pixel alpha is
//   zero or palette_count is zero.
//   palette_count sits at APB byte address 0; write it only while the block is idle.
//   The back end scans one palette entry per cycle through a single memory read port,
//   over the first palette_count entries (capped at 32) for a pixel, and none for a
//   transparent pixel or empty palette. It takes no new item until the result of the
//   current pixel is loaded; a palette write is taken while it is idle.
//   A two-entry queue lets pix_in keep accepting while the back end is busy.
//   Reset clears palette_count, the queue and all valid flags; palette contents are
//   undefined until written. When res_out is stalled the result is held and the back
//   end waits before loading the next one; items queue until the queue is full.
module nearest_palette_color_unit import npc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    npc_in_if.sink             pix_in,
    npc_out_if.source          res_out
);

    logic [COUNT_W-1:0] count_reg;
    logic               cfg_wr;
    logic               front_valid, front_ready;
    npc_cmd_t           front_cmd;
    logic               back_valid, back_ready;
    npc_cmd_t           back_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_PALETTE_COUNT))
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_PALETTE_COUNT)
        begin
            prdata = PDATA_W'(count_reg);
        end
    end

    npc_front u_front (
        .pix_in    (pix_in),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    npc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    npc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count_reg),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res_out   (res_out)
    );

endmodule

// File: sim/npc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the nearest palette colour unit: follows APB writes and items on pix_in,
// predicts each result and compares it with what leaves res_out.
// Depends on npc_pkg and npc_if.
module npc_checker import npc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    npc_in_if                  pix,
    npc_out_if                 res,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] alpha;
    } colour_t;

    typedef struct packed {
        colour_t colour;
        logic    matched;
    } match_t;

    colour_t            palette_shadow [PALETTE_DEPTH];
    logic [COUNT_W-1:0] entries_in_use;
    match_t             expected_matches [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    // closest entry by squared RGB distance; strict less-than keeps the lowest index on a tie
    function automatic match_t nearest_entry(input colour_t px);
        match_t            best;
        logic [DIST_W-1:0] best_dist;
        logic [DIST_W-1:0] sq_dist;
        logic [CHAN_W-1:0] d0;
        logic [CHAN_W-1:0] d1;
        logic [CHAN_W-1:0] d2;
        int                limit;
        best      = '0;
        best_dist = '0;
        limit     = (entries_in_use > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(entries_in_use);
        if (px.alpha != '0)
        begin
            for (int i = 0; i < limit; i++)
            begin
                d0 = (palette_shadow[i].c0 > px.c0) ? palette_shadow[i].c0 - px.c0
                                                    : px.c0 - palette_shadow[i].c0;
                d1 = (palette_shadow[i].c1 > px.c1) ? palette_shadow[i].c1 - px.c1
                                                    : px.c1 - palette_shadow[i].c1;
                d2 = (palette_shadow[i].c2 > px.c2) ? palette_shadow[i].c2 - px.c2
                                                    : px.c2 - palette_shadow[i].c2;
                sq_dist = DIST_W'(d0) * DIST_W'(d0) + DIST_W'(d1) * DIST_W'(d1)
                        + DIST_W'(d2) * DIST_W'(d2);
                if (!best.matched || sq_dist < best_dist)
                begin
                    best.matched = 1'b1;
                    best.colour  = palette_shadow[i];
                    best_dist    = sq_dist;
                end
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_t got;
        match_t want;
        if (!rst_n)
        begin
            expected_matches.delete();
            entries_in_use = '0;
        end
        else
        begin
            // results first: one leaving now always belongs to an older pixel
            if (res.valid && res.ready)
            begin
                got = {res.out_chan0, res.out_chan1, res.out_chan2, res.out_alpha, res.matched};
                if (expected_matches.size() == 0)
                    report($sformatf("result with nothing expected: %h", got));
                else
                begin
                    want = expected_matches.pop_front();
                    if (got.colour.c0 !== want.colour.c0)
                        report($sformatf("out_chan0 %0d, expected %0d",
                                         got.colour.c0, want.colour.c0));
                    if (got.colour.c1 !== want.colour.c1)
                        report($sformatf("out_chan1 %0d, expected %0d",
                                         got.colour.c1, want.colour.c1));
                    if (got.colour.c2 !== want.colour.c2)
                        report($sformatf("out_chan2 %0d, expected %0d",
                                         got.colour.c2, want.colour.c2));
                    if (got.colour.alpha !== want.colour.alpha)
                        report($sformatf("out_alpha %0d, expected %0d",
                                         got.colour.alpha, want.colour.alpha));
                    if (got.matched !== want.matched)
                        report($sformatf("matched %b, expected %b", got.matched, want.matched));
                end
            end
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1:2] == REG_PALETTE_COUNT)
                entries_in_use = pwdata[COUNT_W-1:0];
            if (pix.valid && pix.ready)
            begin
                if (pix.kind == KIND_WRITE)
                begin
                    // writes past the end of the palette are dropped
                    if (int'(pix.entry_index) < PALETTE_DEPTH)
                        palette_shadow[pix.entry_index] =
                            {pix.chan0, pix.chan1, pix.chan2, pix.alpha};
                end
                else
                    expected_matches.push_back(
                        nearest_entry({pix.chan0, pix.chan1, pix.chan2, pix.alpha}));
            end
        end
        pending = expected_matches.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the nearest palette colour unit: clock, reset, APB writes, item
// stimulus, result back-pressure and the verdict. Depends on npc_pkg, npc_if, npc_checker.
module tb;
    import npc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 195;
    localparam int NUM_PHASES     = 8;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int quiet_cycles;
    int items_sent;
    int pixels_sent;
    int src_idle_pct;
    int sink_stall_pct;
    bit hold_start;

    logic [COUNT_W-1:0] phase_counts [NUM_PHASES] = '{32, 1, 63, 17, 32, 0, 8, 33};

    npc_in_if  pix_ch ();
    npc_out_if res_ch ();

    nearest_palette_color_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_ch),
        .res_out (res_ch)
    );

    npc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pix        (pix_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic apb_write(input logic [COUNT_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PALETTE_COUNT, 2'b00};
        pwdata  <= PDATA_W'(count);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input npc_kind_t kind, input logic [ENTRY_W-1:0] idx,
                             input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                             input logic [CHAN_W-1:0] c2, input logic [CHAN_W-1:0] a);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.kind        <= kind;
        pix_ch.entry_index <= idx;
        pix_ch.chan0       <= c0;
        pix_ch.chan1       <= c1;
        pix_ch.chan2       <= c2;
        pix_ch.alpha       <= a;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        items_sent++;
        if (kind == KIND_PIXEL)
            pixels_sent++;
    endtask

    // drop valid, drain every result, then let any trailing palette write finish
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // coarse levels make exact ties between entries common
    function automatic logic [CHAN_W-1:0] pick_chan(input int coarse_pct);
        logic [CHAN_W-1:0] levels [5] = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};
        if ($urandom_range(99) < coarse_pct)
            return levels[$urandom_range(4)];
        return CHAN_W'($urandom_range(255));
    endfunction

    task automatic random_write(input logic [ENTRY_W-1:0] idx);
        send_item(KIND_WRITE, idx, pick_chan(50), pick_chan(50), pick_chan(50),
                  CHAN_W'($urandom_range(255)));
    endtask

    task automatic random_item();
        int                roll;
        logic [CHAN_W-1:0] a;
        if ($urandom_range(99) < 30)
            random_write(ENTRY_W'($urandom_range(31)));
        else
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                a = '0;
            else if (roll < 20)
                a = '1;
            else
                a = CHAN_W'($urandom_range(1, 255));
            send_item(KIND_PIXEL, ENTRY_W'($urandom_range(31)), pick_chan(30), pick_chan(30),
                      pick_chan(30), a);
        end
    endtask

    // result side: random stalls, or one long hold-off when asked
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.kind        = KIND_PIXEL;
        pix_ch.entry_index = '0;
        pix_ch.chan0       = '0;
        pix_ch.chan1       = '0;
        pix_ch.chan2       = '0;
        pix_ch.alpha       = '0;
        quiet_cycles       = 0;
        items_sent         = 0;
        pixels_sent        = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        hold_start         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty palette straight after reset
        send_item(KIND_PIXEL, 5'd31, 8'd200, 8'd100, 8'd50, 8'd255);
        send_item(KIND_PIXEL, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // entries 0 and 2 share a colour, entry 3 carries zero alpha
        send_item(KIND_WRITE, 5'd0, 8'd0, 8'd0, 8'd0, 8'd1);
        send_item(KIND_WRITE, 5'd1, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(KIND_WRITE, 5'd2, 8'd0, 8'd0, 8'd0, 8'd200);
        send_item(KIND_WRITE, 5'd3, 8'd255, 8'd0, 8'd128, 8'd0);
        wait_idle();
        apb_write(6'd4);
        send_item(KIND_PIXEL, 5'd2, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(KIND_PIXEL, 5'd1, 8'd255, 8'd255, 8'd255, 8'd1);
        send_item(KIND_PIXEL, 5'd3, 8'd255, 8'd0, 8'd128, 8'd0);
        send_item(KIND_PIXEL, 5'd0, 8'd254, 8'd1, 8'd127, 8'd128);
        send_item(KIND_PIXEL, 5'd0, 8'd128, 8'd128, 8'd128, 8'd255);
        send_item(KIND_PIXEL, 5'd0, 8'd127, 8'd127, 8'd127, 8'd255);
        wait_idle();
        apb_write(6'd1);
        send_item(KIND_PIXEL, 5'd0, 8'd255, 8'd255, 8'd255, 8'd255);

        // fill the whole palette so that any count may follow
        sink_stall_pct = 12;
        src_idle_pct   = 12;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            random_write(ENTRY_W'(i));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            apb_write(phase_counts[p]);
            case (p % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 88;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 88;
                end
                default:
                begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 12;
                end
            endcase
            // one phase holds results back long enough to back up the input
            if (p == 4)
                hold_start = 1'b1;
            repeat (PHASE_ITEMS) random_item();
        end

        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d items, %0d of them pixels, palette counts 0 to 63 incl. ties,",
                 items_sent, pixels_sent);
        $display("transparent pixels, four idling modes and one long result hold-off.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/npc_pkg.sv
design/npc_if.sv
design/npc_front.sv
design/npc_fifo.sv
design/npc_back.sv
design/nearest_palette_color_unit.sv
sim/npc_checker.sv
sim/tb.sv
